>>> hdl/hdf_pkg.sv
`default_nettype none

package hdf_pkg;

  localparam int unsigned HASH_W = 32;
  localparam int unsigned BYTE_W = 8;

  localparam logic [HASH_W-1:0] FNV_OFFSET_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME        = 32'd16777619;

  typedef struct packed {
    logic [BYTE_W-1:0] key_byte;
    logic              byte_present;
    logic              key_end;
  } hdf_in_t;

  typedef struct packed {
    logic              seen_before;
    logic [HASH_W-1:0] key_hash;
  } hdf_out_t;

  // Lookup token that walks the cell chain.
  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
    logic              hit;
  } hdf_query_t;

endpackage

`default_nettype wire

>>> hdl/hashed_duplicate_filter.sv
// Byte items may be issued back to back while busy is low.
// The key-end beat starts a lookup that walks the chain of RING_DEPTH cells,
// one cell per cycle after the hasher's launch register; its result strobes
// as the token leaves the last cell. busy is high from that accept until the
// result cycle, so no key starts mid-lookup; the receiver cannot stall.
// Reset clears all slots to empty, the running hash to the offset basis.
`default_nettype none

module hashed_duplicate_filter
  import hdf_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire hdf_in_t  item_i,
  output logic          result_valid_o,
  output hdf_out_t      result_o
);

  hdf_query_t        chain   [RING_DEPTH+1];
  logic [HASH_W-1:0] slots   [RING_DEPTH+1];
  logic [RING_DEPTH:0] chain_valid;
  logic              accept;
  logic              shift;
  logic              busy_q, busy_d;
  hdf_query_t        tail;

  assign accept = start & ~busy;
  assign tail   = chain[RING_DEPTH];

  hdf_hasher u_hasher (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .launch_o (chain[0])
  );

  // A miss at the tail pushes the new hash into the head of the ring.
  assign shift    = tail.valid & ~tail.hit;
  assign slots[0] = tail.hash;

  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    hdf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .query_i (chain[i]),
      .shift_i (shift),
      .slot_i  (slots[i]),
      .query_o (chain[i+1]),
      .slot_o  (slots[i+1])
    );
  end

  for (genvar i = 0; i <= RING_DEPTH; i++) begin : g_valid
    assign chain_valid[i] = chain[i].valid;
  end

  always_comb begin
    busy_d = busy_q;
    if (tail.valid) begin
      busy_d = 1'b0;
    end
    if (accept && item_i.key_end) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  assign busy                 = busy_q & ~tail.valid;
  assign result_valid_o       = tail.valid;
  assign result_o.seen_before = tail.hit;
  assign result_o.key_hash    = tail.hash;

`ifndef ASSERT_OFF
  a_hash_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> result_o.key_hash[0])
    else $error("result hash has low bit clear");

  a_one_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(chain_valid))
    else $error("more than one lookup in the cell chain");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.key_end) |-> ##(RING_DEPTH+1) result_valid_o)
    else $error("lookup result missing at expected cycle");

  a_busy_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_valid != '0) |-> busy_q)
    else $error("lookup in flight while not busy");
`endif

endmodule

`default_nettype wire

>>> hdl/hdf_hasher.sv
`default_nettype none

module hdf_hasher
  import hdf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire hdf_in_t    item_i,
  output hdf_query_t      launch_o
);

  logic [HASH_W-1:0] running_q, running_d;
  logic [HASH_W-1:0] product;
  logic [HASH_W-1:0] folded;
  hdf_query_t        launch_q, launch_d;

  assign product = HASH_W'((running_q ^ HASH_W'(item_i.key_byte)) * FNV_PRIME);
  assign folded  = item_i.byte_present ? product : running_q;

  always_comb begin
    running_d      = running_q;
    launch_d       = launch_q;
    launch_d.valid = 1'b0;
    if (accept_i) begin
      if (item_i.key_end) begin
        // Force the low bit so a final hash never looks like an empty slot.
        launch_d.valid = 1'b1;
        launch_d.hash  = folded | HASH_W'(1);
        launch_d.hit   = 1'b0;
        running_d      = FNV_OFFSET_BASIS;
      end else begin
        running_d = folded;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= FNV_OFFSET_BASIS;
      launch_q  <= '0;
    end else begin
      running_q <= running_d;
      launch_q  <= launch_d;
    end
  end

  assign launch_o = launch_q;

endmodule

`default_nettype wire

>>> hdl/hdf_cell.sv
`default_nettype none

module hdf_cell
  import hdf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hdf_query_t        query_i,
  input  wire logic              shift_i,
  input  wire logic [HASH_W-1:0] slot_i,
  output hdf_query_t             query_o,
  output logic [HASH_W-1:0]      slot_o
);

  logic [HASH_W-1:0] slot_q, slot_d;
  hdf_query_t        query_q, query_d;

  always_comb begin
    query_d     = query_i;
    query_d.hit = query_i.hit | (query_i.valid & (slot_q == query_i.hash));
    // Insert moves every slot one cell down; the last one drops out.
    slot_d      = shift_i ? slot_i : slot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      query_q <= '0;
    end else begin
      slot_q  <= slot_d;
      query_q <= query_d;
    end
  end

  assign query_o = query_q;
  assign slot_o  = slot_q;

endmodule

`default_nettype wire
